>>> design/tvbb_pkg.sv
// Shared constants and types for the transformed vertex bounding box unit.
package tvbb_pkg;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int RESULT_W  = 32;
  localparam int AXES      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X = 2'd0,
    CFG_ROW_Y = 2'd1,
    CFG_ROW_Z = 2'd2
  } cfg_reg_t;

  // Identity rows: 1.0 in Q8.8 on the diagonal.
  localparam logic [CFG_W-1:0] ROW_X_RST = 64'd256;
  localparam logic [CFG_W-1:0] ROW_Y_RST = 64'd16777216;
  localparam logic [CFG_W-1:0] ROW_Z_RST = 64'd1099511627776;

endpackage

>>> design/tvbb_row.sv
// One matrix row: four products, then sum, arithmetic shift and saturation.
module tvbb_row import tvbb_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          prod_en,
  input  logic                          sum_en,
  input  logic [CFG_W-1:0]              coef,
  input  logic signed [COORD_WIDTH-1:0] vert_x,
  input  logic signed [COORD_WIDTH-1:0] vert_y,
  input  logic signed [COORD_WIDTH-1:0] vert_z,
  input  logic signed [COORD_WIDTH-1:0] vert_w,
  output logic signed [RESULT_W-1:0]    result
);

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int ACC_W  = (PROD_W + 2 > CFG_W) ? CFG_W : PROD_W + 2;
  localparam int EXT_W  = (ACC_W > RESULT_W) ? ACC_W : RESULT_W + 1;

  logic signed [COORD_WIDTH-1:0] lane [4];
  logic signed [COORD_WIDTH-1:0] vert [4];
  logic signed [PROD_W-1:0]      prod_r [4];
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [EXT_W-1:0]       ext;
  logic [EXT_W-RESULT_W:0]       ext_hi;
  logic signed [RESULT_W-1:0]    sat_nxt;
  logic signed [RESULT_W-1:0]    result_r;

  assign vert[0] = vert_x;
  assign vert[1] = vert_y;
  assign vert[2] = vert_z;
  assign vert[3] = vert_w;

  // Lanes wholly above the register read as zero; a straddling lane keeps its low bits.
  for (genvar c = 0; c < 4; c++) begin : g_lane
    localparam int SH = c * COORD_WIDTH;
    if (SH >= CFG_W) begin : g_zero
      assign lane[c] = '0;
    end else begin : g_take
      logic [CFG_W-1:0] lane_shifted;
      assign lane_shifted = coef >> SH;
      assign lane[c] = lane_shifted[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c] <= lane[c] * vert[c];
      end
    end
  end

  always_comb begin
    acc     = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
            + ACC_W'(prod_r[3]);
    shifted = acc >>> FRAC_BITS;
    ext     = EXT_W'(shifted);
    ext_hi  = ext[EXT_W-1:RESULT_W-1];
    if (ext_hi == '0 || ext_hi == '1) begin
      sat_nxt = ext[RESULT_W-1:0];
    end else if (ext[EXT_W-1]) begin
      sat_nxt = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      sat_nxt = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      result_r <= sat_nxt;
    end
  end

  assign result = result_r;

endmodule

>>> design/transformed_vertex_bounding_box_unit.sv
// Stages are product, row sum/saturate and bound update; out_valid rises once a last
// vertex is taken into the bounds. Throughput: one vertex per cycle when not stalled.
// An unconsumed result only holds the pipe once a further last vertex reaches the bounds.
// Reset: matrix rows to identity, pipeline empty, next vertex opens a new list.
module transformed_vertex_bounding_box_unit import tvbb_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_z,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_w,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [RESULT_W-1:0]    out_min_x,
  output logic signed [RESULT_W-1:0]    out_max_x,
  output logic signed [RESULT_W-1:0]    out_min_y,
  output logic signed [RESULT_W-1:0]    out_max_y,
  output logic signed [RESULT_W-1:0]    out_min_z,
  output logic signed [RESULT_W-1:0]    out_max_z
);

  logic [CFG_W-1:0] row_r [AXES];
  logic [CFG_W-1:0] row_nxt [AXES];

  logic p_valid_r, p_last_r, t_valid_r, t_last_r, list_start_r, out_valid_r;
  logic in_fire, p_move, t_take, t_ready, p_ready, out_fire;

  logic signed [RESULT_W-1:0] t_val [AXES];
  logic signed [RESULT_W-1:0] low_r [AXES];
  logic signed [RESULT_W-1:0] high_r [AXES];
  logic signed [RESULT_W-1:0] low_nxt [AXES];
  logic signed [RESULT_W-1:0] high_nxt [AXES];
  logic signed [RESULT_W-1:0] res_low_r [AXES];
  logic signed [RESULT_W-1:0] res_high_r [AXES];

  // Configuration writes.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      row_nxt[a] = row_r[a];
    end
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROW_X: row_nxt[0] = cfg_data;
        CFG_ROW_Y: row_nxt[1] = cfg_data;
        CFG_ROW_Z: row_nxt[2] = cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RST;
      row_r[1] <= ROW_Y_RST;
      row_r[2] <= ROW_Z_RST;
    end else begin
      for (int a = 0; a < AXES; a++) begin
        row_r[a] <= row_nxt[a];
      end
    end
  end

  // Pipeline flow: a non-last transaction always drains into the bounds.
  assign out_fire = out_valid_r && !out_stall;
  assign t_take   = t_valid_r && (!t_last_r || !out_valid_r || !out_stall);
  assign t_ready  = !t_valid_r || t_take;
  assign p_move   = p_valid_r && t_ready;
  assign p_ready  = !p_valid_r || t_ready;
  assign in_stall = !p_ready;
  assign in_fire  = in_valid && p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      t_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= in_valid;
      end
      if (t_ready) begin
        t_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_last_r <= in_last_vertex;
    end
    if (p_move) begin
      t_last_r <= p_last_r;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_row
    tvbb_row #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_row (
      .clk    (clk),
      .prod_en(in_fire),
      .sum_en (p_move),
      .coef   (row_r[a]),
      .vert_x (in_vertex_x),
      .vert_y (in_vertex_y),
      .vert_z (in_vertex_z),
      .vert_w (in_vertex_w),
      .result (t_val[a])
    );
  end

  // Bound update: the opening vertex of a list loads both bounds.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (list_start_r) begin
        low_nxt[a]  = t_val[a];
        high_nxt[a] = t_val[a];
      end else begin
        low_nxt[a]  = (t_val[a] < low_r[a])  ? t_val[a] : low_r[a];
        high_nxt[a] = (t_val[a] > high_r[a]) ? t_val[a] : high_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_take) begin
      for (int a = 0; a < AXES; a++) begin
        low_r[a]  <= low_nxt[a];
        high_r[a] <= high_nxt[a];
      end
      if (t_last_r) begin
        for (int a = 0; a < AXES; a++) begin
          res_low_r[a]  <= low_nxt[a];
          res_high_r[a] <= high_nxt[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (t_take) begin
        list_start_r <= t_last_r;
      end
      if (t_take && t_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_min_x = res_low_r[0];
  assign out_max_x = res_high_r[0];
  assign out_min_y = res_low_r[1];
  assign out_max_y = res_high_r[1];
  assign out_min_z = res_low_r[2];
  assign out_max_z = res_high_r[2];

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the transformed vertex bounding box unit.
`timescale 1ns / 1ps

module testbench;
  import tvbb_pkg::*;

  localparam int COORD_W      = 16;
  localparam int FRAC         = 8;
  localparam int RANDOM_ITEMS = 1450;
  localparam int SETTLE       = 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
    logic                      last;
  } vertex_t;

  typedef struct {
    logic signed [RESULT_W-1:0] min_x;
    logic signed [RESULT_W-1:0] max_x;
    logic signed [RESULT_W-1:0] min_y;
    logic signed [RESULT_W-1:0] max_y;
    logic signed [RESULT_W-1:0] min_z;
    logic signed [RESULT_W-1:0] max_z;
  } bounds_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

  class bbox_scoreboard;
    logic [CFG_W-1:0] rows[AXES];
    int               lo[AXES];
    int               hi[AXES];
    bit               opening;
    bounds_t          bounds_q[$];
    int               errors;

    function new();
      rows[CFG_ROW_X] = ROW_X_RST;
      rows[CFG_ROW_Y] = ROW_Y_RST;
      rows[CFG_ROW_Z] = ROW_Z_RST;
      for (int i = 0; i < AXES; i++) begin
        lo[i] = 0;
        hi[i] = 0;
      end
      opening = 1'b1;
      errors  = 0;
    endfunction

    function void set_row(cfg_reg_t idx, logic [CFG_W-1:0] val);
      rows[idx] = val;
    endfunction

    function int pending();
      return bounds_q.size();
    endfunction

    // Exact dot product of one matrix row, floor shift, clamp to 32 bits.
    function int transform(logic [CFG_W-1:0] row, vertex_t v);
      longint acc;
      longint sh;
      acc = longint'($signed(row[15:0]))  * longint'(v.x)
          + longint'($signed(row[31:16])) * longint'(v.y)
          + longint'($signed(row[47:32])) * longint'(v.z)
          + longint'($signed(row[63:48])) * longint'(v.w);
      sh = acc >>> FRAC;
      if (sh > SAT_HI) return int'(SAT_HI);
      if (sh < SAT_LO) return int'(SAT_LO);
      return int'(sh);
    endfunction

    function void note_vertex(vertex_t v);
      int      t[AXES];
      bounds_t b;
      t[0] = transform(rows[CFG_ROW_X], v);
      t[1] = transform(rows[CFG_ROW_Y], v);
      t[2] = transform(rows[CFG_ROW_Z], v);
      for (int i = 0; i < AXES; i++) begin
        if (opening) begin
          lo[i] = t[i];
          hi[i] = t[i];
        end else begin
          if (t[i] < lo[i]) lo[i] = t[i];
          if (t[i] > hi[i]) hi[i] = t[i];
        end
      end
      opening = v.last;
      if (v.last) begin
        b.min_x = lo[0];
        b.max_x = hi[0];
        b.min_y = lo[1];
        b.max_y = hi[1];
        b.min_z = lo[2];
        b.max_z = hi[2];
        bounds_q.push_back(b);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic signed [RESULT_W-1:0] got,
                       logic signed [RESULT_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_bounds(bounds_t got);
      bounds_t want;
      if (bounds_q.size() == 0) begin
        report($sformatf("result transaction with no list closed (min_x %0d)", got.min_x));
        return;
      end
      want = bounds_q.pop_front();
      compare_field("min_x", got.min_x, want.min_x);
      compare_field("max_x", got.max_x, want.max_x);
      compare_field("min_y", got.min_y, want.min_y);
      compare_field("max_y", got.max_y, want.max_y);
      compare_field("min_z", got.min_z, want.min_z);
      compare_field("max_z", got.max_z, want.max_z);
    endtask
  endclass

  logic                        clk;
  logic                        rst_n          = 1'b0;
  logic                        cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index      = CFG_ROW_X;
  logic [CFG_W-1:0]            cfg_data       = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic signed [COORD_W-1:0]   in_vertex_x    = '0;
  logic signed [COORD_W-1:0]   in_vertex_y    = '0;
  logic signed [COORD_W-1:0]   in_vertex_z    = '0;
  logic signed [COORD_W-1:0]   in_vertex_w    = '0;
  logic                        in_last_vertex = 1'b0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic signed [RESULT_W-1:0]  out_min_x;
  logic signed [RESULT_W-1:0]  out_max_x;
  logic signed [RESULT_W-1:0]  out_min_y;
  logic signed [RESULT_W-1:0]  out_max_y;
  logic signed [RESULT_W-1:0]  out_min_z;
  logic signed [RESULT_W-1:0]  out_max_z;

  bbox_scoreboard sb;
  bounds_t        seen_bounds;
  int             burst_left = 0;
  int             idle_cycles;
  int             rx_left = 0;
  rx_mode_t       rx_mode = RX_OPEN;

  transformed_vertex_bounding_box_unit #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .in_vertex_z   (in_vertex_z),
    .in_vertex_w   (in_vertex_w),
    .in_last_vertex(in_last_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_min_x     (out_min_x),
    .out_max_x     (out_max_x),
    .out_min_y     (out_min_y),
    .out_max_y     (out_max_y),
    .out_min_z     (out_min_z),
    .out_max_z     (out_max_z)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: switch between open, light, heavy and solid stall stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(1, 64);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_bounds.min_x = out_min_x;
      seen_bounds.max_x = out_max_x;
      seen_bounds.min_y = out_min_y;
      seen_bounds.max_y = out_max_y;
      seen_bounds.min_z = out_min_z;
      seen_bounds.max_z = out_max_z;
      sb.check_bounds(seen_bounds);
    end
  end

  // Watchdog: end the run after too many cycles without any transaction.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return '1;
      4, 5:    return COORD_W'($urandom_range(0, 1023) - 512);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_row();
    logic [CFG_W-1:0] r;
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return {4{16'h8000}};
      3: return {4{16'h7FFF}};
      default: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(0, 7))
            0:       r[16*i +: 16] = 16'h0100;
            1:       r[16*i +: 16] = 16'h0000;
            2:       r[16*i +: 16] = 16'h8000;
            3:       r[16*i +: 16] = 16'h7FFF;
            4:       r[16*i +: 16] = 16'hFFFF;
            default: r[16*i +: 16] = 16'($urandom());
          endcase
        end
        return r;
      end
    endcase
  endfunction

  function automatic int pick_list_len();
    case ($urandom_range(0, 9))
      0, 1, 2: return 1;
      8:       return $urandom_range(9, 40);
      9:       return $urandom_range(41, 120);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic signed [COORD_W-1:0] w,
                             logic last);
    vertex_t v;
    v.x    = x;
    v.y    = y;
    v.z    = z;
    v.w    = w;
    v.last = last;
    // Insert a gap between bursts.
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_vertex_x    <= v.x;
    in_vertex_y    <= v.y;
    in_vertex_z    <= v.z;
    in_vertex_w    <= v.w;
    in_last_vertex <= v.last;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(v);
  endtask

  task automatic write_row(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_row(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off input until every closed list has reported and the pipe is empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int items;
    int list_left;
    int phase_left;
    sb = new();
    wait (rst_n === 1'b1);

    // Identity rows straight out of reset; single-vertex list first.
    send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd256, 1'b1);
    send_vertex(16'sd32767, -16'sd32768, 16'sd1, 16'sd256, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, -16'sd1, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    drain();

    write_row(CFG_ROW_X, '1);
    write_row(CFG_ROW_Y, {4{16'h8000}});
    write_row(CFG_ROW_Z, {4{16'h7FFF}});
    send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    drain();

    write_row(CFG_ROW_X, '0);
    write_row(CFG_ROW_Y, '0);
    write_row(CFG_ROW_Z, '0);
    send_vertex(16'sd1234, -16'sd77, 16'sd300, 16'sd256, 1'b1);
    drain();

    // Restore identity rows, open a list, and rewrite the matrix in the middle of it.
    write_row(CFG_ROW_X, ROW_X_RST);
    write_row(CFG_ROW_Y, ROW_Y_RST);
    write_row(CFG_ROW_Z, ROW_Z_RST);
    send_vertex(pick_coord(), pick_coord(), pick_coord(), 16'sd256, 1'b0);
    send_vertex(pick_coord(), pick_coord(), pick_coord(), 16'sd256, 1'b0);
    drain();
    write_row(CFG_ROW_X, pick_row());
    write_row(CFG_ROW_Y, pick_row());
    send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0);
    send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b1);

    items     = 0;
    list_left = 0;
    while (items < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(0, 3) == 0) begin
        write_row(CFG_ROW_X, ROW_X_RST);
        write_row(CFG_ROW_Y, ROW_Y_RST);
        write_row(CFG_ROW_Z, ROW_Z_RST);
      end else begin
        for (int i = 0; i < AXES; i++)
          if ($urandom_range(0, 1) == 1) write_row(cfg_reg_t'(i), pick_row());
      end
      // A phase may end mid-list; the list then spans the register update.
      phase_left = $urandom_range(100, 260);
      while (phase_left > 0 && items < RANDOM_ITEMS) begin
        if (list_left == 0) list_left = pick_list_len();
        list_left--;
        send_vertex(pick_coord(), pick_coord(), pick_coord(),
                    ($urandom_range(0, 1) == 1) ? 16'sd256 : pick_coord(),
                    list_left == 0);
        items++;
        phase_left--;
      end
    end
    if (list_left != 0)
      send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b1);

    drain();
    if (sb.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

>>> sim.f
design/tvbb_pkg.sv
design/tvbb_row.sv
design/transformed_vertex_bounding_box_unit.sv
dv/testbench.sv
